// ===== hw/rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch seconds to calendar converter:
// controller/datapath command and status structs, divisor codes, month table.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned EpochW     = 31;
  localparam int unsigned DivW       = 32;
  localparam int unsigned ProdW      = 2 * DivW;
  localparam int unsigned DivSteps   = 2;   // quotient cycle, then remainder cycle
  localparam int unsigned DivCntW    = $clog2(DivSteps);
  localparam int unsigned RemW       = 6;   // remainder of the largest divisor, 60
  localparam int unsigned DaysW      = 15;  // whole days since the epoch
  localparam int unsigned YearW      = 11;
  localparam int unsigned MonthW     = 4;

  // Reciprocals ceil(2^k / d); the quotient is exact for any dividend below 2^31
  localparam logic [DivW-1:0]   Recip60       = 32'd2290649225;
  localparam int unsigned       Shift60       = 37;
  localparam logic [DivW-1:0]   Recip24       = 32'd2863311531;
  localparam int unsigned       Shift24       = 36;
  localparam logic [DivW-1:0]   Recip7        = 32'd2454267027;
  localparam int unsigned       Shift7        = 34;

  localparam logic [YearW-1:0]  EpochYear     = 11'd1970;
  localparam logic [6:0]        EpochYearM100 = 7'd70;
  localparam logic [8:0]        EpochYearM400 = 9'd370;
  localparam logic [6:0]        M100Last      = 7'd99;
  localparam logic [8:0]        M400Last      = 9'd399;
  localparam logic [MonthW-1:0] MonthJan      = 4'd0;
  localparam logic [MonthW-1:0] MonthFeb      = 4'd1;
  localparam logic [MonthW-1:0] MonthDec      = 4'd11;
  localparam logic [DivW-1:0]   EpochWeekday  = 32'd4;  // the epoch day is a Thursday

  typedef enum logic [1:0] {
    DIV_SEL_60 = 2'd0,
    DIV_SEL_24 = 2'd1,
    DIV_SEL_7  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    div_sel_e div_sel;
    logic     store_sec;
    logic     store_min;
    logic     store_hour;
    logic     store_wday;
    logic     year_step;
    logic     month_step;
  } esc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } esc_status_t;

  function automatic logic [RemW-1:0] div_value(input div_sel_e sel);
    logic [RemW-1:0] v;
    case (sel)
      DIV_SEL_60: v = 6'd60;
      DIV_SEL_24: v = 6'd24;
      DIV_SEL_7:  v = 6'd7;
      default:    v = 6'd60;
    endcase
    return v;
  endfunction

  // Month length in a common year
  function automatic logic [4:0] month_days(input logic [MonthW-1:0] m);
    logic [4:0] d;
    case (m)
      4'd0:    d = 5'd31;
      4'd1:    d = 5'd28;
      4'd2:    d = 5'd31;
      4'd3:    d = 5'd30;
      4'd4:    d = 5'd31;
      4'd5:    d = 5'd30;
      4'd6:    d = 5'd31;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd30;
      4'd9:    d = 5'd31;
      4'd10:   d = 5'd30;
      4'd11:   d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 00:00:00 into time of day, weekday and
// Gregorian date.
//
// Request: drive epoch_seconds_i and raise start_i; the transaction is taken
// at a rising edge with start_i high and busy_o low. busy_o stays high until
// the result has been delivered, and no new request is taken meanwhile.
// Result: all fields are valid during the single cycle in which valid_o is
// high; the receiver must take them then, since it has no way to stall.
// Fields hold their values afterwards until the next request runs.
// valid_o rises once the sequencer has run four constant divisions (each a
// quotient step, then a remainder step), stepped off the Y whole years
// (Y = 0..68) and stepped off the M whole months (M = 0..11).
// busy_o drops the cycle after valid_o, so the next request is accepted only
// once the previous result has been delivered.
// Reset returns the sequencer to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [30:0] epoch_seconds_i,
  output logic        valid_o,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [2:0]  weekday_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_index_o,
  output logic [10:0] year_number_o
);

  esc_pkg::esc_cmd_t    cmd;
  esc_pkg::esc_status_t status;

  esc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .valid_o  (valid_o)
  );

  esc_dpath u_dpath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .epoch_seconds_i    (epoch_seconds_i),
    .status_o           (status),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .weekday_o          (weekday_o),
    .day_of_month_o     (day_of_month_o),
    .month_index_o      (month_index_o),
    .year_number_o      (year_number_o)
  );

endmodule

// ===== hw/rtl/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: runs the four constant divisions, then the year and month
// walks, and strobes the finished result.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  esc_pkg::esc_status_t status_i,
  output esc_pkg::esc_cmd_t    cmd_o,
  output logic                busy_o,
  output logic                valid_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DIV_SEC  = 8'b0000_0010,
    ST_DIV_MIN  = 8'b0000_0100,
    ST_DIV_HOUR = 8'b0000_1000,
    ST_DIV_WDAY = 8'b0001_0000,
    ST_YEAR     = 8'b0010_0000,
    ST_MONTH    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

  state_e                        state_q, state_d;
  logic [esc_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic                          last_step;

  assign last_step = (cnt_q == esc_pkg::DivCntW'(esc_pkg::DivSteps - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.div_sel = esc_pkg::DIV_SEL_60;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV_SEC;
        end
      end
      ST_DIV_SEC: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.store_sec = last_step;
        cnt_d           = cnt_q + 1'b1;
        if (last_step) state_d = ST_DIV_MIN;
      end
      ST_DIV_MIN: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.store_min = last_step;
        cnt_d           = cnt_q + 1'b1;
        if (last_step) state_d = ST_DIV_HOUR;
      end
      ST_DIV_HOUR: begin
        cmd_o.div_step   = 1'b1;
        cmd_o.div_sel    = esc_pkg::DIV_SEL_24;
        cmd_o.store_hour = last_step;
        cnt_d            = cnt_q + 1'b1;
        if (last_step) state_d = ST_DIV_WDAY;
      end
      ST_DIV_WDAY: begin
        cmd_o.div_step   = 1'b1;
        cmd_o.div_sel    = esc_pkg::DIV_SEL_7;
        cmd_o.store_wday = last_step;
        cnt_d            = cnt_q + 1'b1;
        if (last_step) state_d = ST_YEAR;
      end
      ST_YEAR: begin
        cmd_o.year_step = 1'b1;
        if (status_i.year_done) state_d = ST_MONTH;
      end
      ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        if (status_i.month_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_DONE);

endmodule

// ===== hw/rtl/esc_dpath.sv =====
// ----------------------------------------------------------------------------
// esc_dpath
// Datapath: reciprocal-multiply constant divider for the time-of-day and
// weekday fields, plus day counter with year and month walkers.
// ----------------------------------------------------------------------------
module esc_dpath (
  input  logic                         clk_i,
  input  esc_pkg::esc_cmd_t             cmd_i,
  input  logic [esc_pkg::EpochW-1:0]   epoch_seconds_i,
  output esc_pkg::esc_status_t          status_o,
  output logic [5:0]                   second_of_minute_o,
  output logic [5:0]                   minute_of_hour_o,
  output logic [4:0]                   hour_of_day_o,
  output logic [2:0]                   weekday_o,
  output logic [4:0]                   day_of_month_o,
  output logic [esc_pkg::MonthW-1:0]   month_index_o,
  output logic [esc_pkg::YearW-1:0]    year_number_o
);

  logic [esc_pkg::DivW-1:0]   dq_q;       // dividend, replaced by its quotient
  logic [esc_pkg::DivW-1:0]   quo_q;
  logic [esc_pkg::DivW-1:0]   recip;
  logic [esc_pkg::ProdW-1:0]  product;
  logic [esc_pkg::DivW-1:0]   quo;
  logic [esc_pkg::RemW-1:0]   rem;
  logic [esc_pkg::RemW-1:0]   divisor;

  logic [5:0]                 sec_q, min_q;
  logic [4:0]                 hour_q;
  logic [2:0]                 wday_q;
  logic [esc_pkg::DaysW-1:0]  days_q;
  logic [esc_pkg::YearW-1:0]  year_q;
  logic [6:0]                 m100_q;
  logic [8:0]                 m400_q;
  logic [esc_pkg::MonthW-1:0] month_q;

  logic                       leap;
  logic [8:0]                 year_len;
  logic [4:0]                 month_len;

  assign divisor = esc_pkg::div_value(cmd_i.div_sel);

  // Quotient by reciprocal multiply, registered into quo_q; remainder from it in the next cycle
  always_comb begin
    case (cmd_i.div_sel)
      esc_pkg::DIV_SEL_60: recip = esc_pkg::Recip60;
      esc_pkg::DIV_SEL_24: recip = esc_pkg::Recip24;
      esc_pkg::DIV_SEL_7:  recip = esc_pkg::Recip7;
      default:             recip = esc_pkg::Recip60;
    endcase
    product = esc_pkg::ProdW'(dq_q) * esc_pkg::ProdW'(recip);
    case (cmd_i.div_sel)
      esc_pkg::DIV_SEL_60: quo = esc_pkg::DivW'(product >> esc_pkg::Shift60);
      esc_pkg::DIV_SEL_24: quo = esc_pkg::DivW'(product >> esc_pkg::Shift24);
      esc_pkg::DIV_SEL_7:  quo = esc_pkg::DivW'(product >> esc_pkg::Shift7);
      default:             quo = esc_pkg::DivW'(product >> esc_pkg::Shift60);
    endcase
  end

  // The remainder is below 64, so the low bits of the difference suffice
  assign rem = dq_q[esc_pkg::RemW-1:0] -
               esc_pkg::RemW'(quo_q[esc_pkg::RemW-1:0] * divisor);

  assign leap      = ((year_q[1:0] == 2'b00) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign year_len  = leap ? 9'd366 : 9'd365;
  assign month_len = esc_pkg::month_days(month_q) +
                     5'((month_q == esc_pkg::MonthFeb) && leap);

  assign status_o.year_done  = (days_q < esc_pkg::DaysW'(year_len));
  assign status_o.month_done = (days_q < esc_pkg::DaysW'(month_len)) ||
                               (month_q == esc_pkg::MonthDec);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dq_q    <= esc_pkg::DivW'(epoch_seconds_i);
      year_q  <= esc_pkg::EpochYear;
      m100_q  <= esc_pkg::EpochYearM100;
      m400_q  <= esc_pkg::EpochYearM400;
      month_q <= esc_pkg::MonthJan;
    end else if (cmd_i.div_step) begin
      if (cmd_i.store_hour) begin
        // Keep the day count and seed the weekday division with it
        hour_q <= rem[4:0];
        days_q <= quo_q[esc_pkg::DaysW-1:0];
        dq_q   <= esc_pkg::DivW'(quo_q[esc_pkg::DaysW-1:0]) + esc_pkg::EpochWeekday;
      end else if (cmd_i.store_sec || cmd_i.store_min || cmd_i.store_wday) begin
        dq_q <= quo_q;
        if (cmd_i.store_sec)  sec_q  <= rem;
        if (cmd_i.store_min)  min_q  <= rem;
        if (cmd_i.store_wday) wday_q <= rem[2:0];
      end else begin
        quo_q <= quo;
      end
    end else if (cmd_i.year_step && !status_o.year_done) begin
      days_q <= days_q - esc_pkg::DaysW'(year_len);
      year_q <= year_q + 1'b1;
      m100_q <= (m100_q == esc_pkg::M100Last) ? 7'd0 : m100_q + 1'b1;
      m400_q <= (m400_q == esc_pkg::M400Last) ? 9'd0 : m400_q + 1'b1;
    end else if (cmd_i.month_step && !status_o.month_done) begin
      days_q  <= days_q - esc_pkg::DaysW'(month_len);
      month_q <= month_q + 1'b1;
    end
  end

  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hour_q;
  assign weekday_o          = wday_q;
  assign day_of_month_o     = days_q[4:0] + 5'd1;
  assign month_index_o      = month_q;
  assign year_number_o      = year_q;

endmodule

// ===== tb/tb_epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Self-checking bench for the epoch seconds to calendar converter. Requests
// are issued through the start/busy handshake with random spacing, each
// accepted request is converted by a behavioral calendar model, and every
// valid_o strobe is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemCount   = 800;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 130;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned DirectedCnt = 22;

  localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Epoch, minute/hour/day/month/year edges, leap days and the top of the range
  localparam logic [30:0] DirectedSecs [DirectedCnt] = '{
    31'd0,          31'd1,          31'd59,         31'd60,
    31'd3599,       31'd3600,       31'd86399,      31'd86400,
    31'd2678399,    31'd2678400,    31'd31535999,   31'd31536000,
    31'd68169600,   31'd68256000,   31'd94694399,   31'd94694400,
    31'd946684799,  31'd951782400,  31'd978307199,  31'd2145916800,
    31'd1073741824, 31'd2147483647
  };

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [10:0] year;
  } calendar_t;

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  class calendar_scoreboard;
    calendar_t   pending_dates[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned leap_days;
    int unsigned first_year;
    int unsigned last_year;

    function new();
      mismatches = 0;
      checked    = 0;
      leap_days  = 0;
      first_year = 9999;
      last_year  = 0;
    endfunction

    function calendar_t convert(logic [30:0] secs);
      calendar_t   r;
      int unsigned t;
      int unsigned days;
      int unsigned yr;
      int unsigned mon;
      int unsigned len;
      t      = 32'(secs);
      r.sec  = 6'(t % 60);
      t      = t / 60;
      r.min  = 6'(t % 60);
      t      = t / 60;
      r.hour = 5'(t % 24);
      days   = t / 24;
      r.wday = 3'((days + esc_pkg::EpochWeekday) % 7);
      yr = 32'(esc_pkg::EpochYear);
      forever begin
        len = is_leap_year(yr) ? 366 : 365;
        if (days < len) break;
        days -= len;
        yr++;
      end
      mon = 32'(esc_pkg::MonthJan);
      forever begin
        len = MonthLen[mon];
        if (mon == esc_pkg::MonthFeb && is_leap_year(yr)) len++;
        if (days < len || mon == esc_pkg::MonthDec) break;
        days -= len;
        mon++;
      end
      r.mday  = 5'(days + 1);
      r.month = 4'(mon);
      r.year  = 11'(yr);
      return r;
    endfunction

    function void note_request(logic [30:0] secs);
      pending_dates.push_back(convert(secs));
    endfunction

    function int unsigned pending();
      return pending_dates.size();
    endfunction

    function void check_result(calendar_t got);
      calendar_t exp;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                   got.year, got.month, got.mday, got.hour, got.min, got.sec, got.wday);
        return;
      end
      exp = pending_dates.pop_front();
      checked++;
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch%s%s%s%s%s%s%s", $realtime,
                   (got.year  !== exp.year)  ? " year"  : "",
                   (got.month !== exp.month) ? " month" : "",
                   (got.mday  !== exp.mday)  ? " mday"  : "",
                   (got.hour  !== exp.hour)  ? " hour"  : "",
                   (got.min   !== exp.min)   ? " min"   : "",
                   (got.sec   !== exp.sec)   ? " sec"   : "",
                   (got.wday  !== exp.wday)  ? " wday"  : "");
          $display("  exp %0d-%0d-%0d %0d:%0d:%0d wd %0d, got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                   exp.year, exp.month, exp.mday, exp.hour, exp.min, exp.sec, exp.wday,
                   got.year, got.month, got.mday, got.hour, got.min, got.sec, got.wday);
        end
      end
      if (exp.year < first_year) first_year = exp.year;
      if (exp.year > last_year) last_year = exp.year;
      if (exp.month == esc_pkg::MonthFeb && exp.mday == 29) leap_days++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [30:0] epoch_seconds_i;
  logic        valid_o;
  logic [5:0]  second_of_minute_o;
  logic [5:0]  minute_of_hour_o;
  logic [4:0]  hour_of_day_o;
  logic [2:0]  weekday_o;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_index_o;
  logic [10:0] year_number_o;

  calendar_scoreboard date_board = new();
  int unsigned        idle_cycles;
  int unsigned        requests_sent;

  epoch_seconds_to_calendar dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .epoch_seconds_i,
    .valid_o,
    .second_of_minute_o,
    .minute_of_hour_o,
    .hour_of_day_o,
    .weekday_o,
    .day_of_month_o,
    .month_index_o,
    .year_number_o
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) date_board.note_request(epoch_seconds_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      date_board.check_result('{sec: second_of_minute_o, min: minute_of_hour_o,
                                hour: hour_of_day_o, wday: weekday_o,
                                mday: day_of_month_o, month: month_index_o,
                                year: year_number_o});
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Hold start_i until the handshake completes, then drop it and wait out the gap
  task automatic send_request(logic [30:0] secs, int unsigned gap);
    start_i         <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
    if (gap > 0) begin
      start_i         <= 1'b0;
      epoch_seconds_i <= 31'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Step past the accepting edge first so its prediction is already queued
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (date_board.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    longint      secs;
    int unsigned yr;
    int unsigned days;
    bit          quiet;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    epoch_seconds_i = '0;
    requests_sent   = 0;
    quiet           = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedCnt; i++) send_request(DirectedSecs[i], pick_gap(i < 8));
    wait_drained();

    for (int i = 0; i < ItemCount; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 9) < 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: secs = longint'($urandom & 32'h7FFF_FFFF);
        5, 6: begin
          // land near a new year, leap or not
          yr   = $urandom_range(1971, 2038);
          days = 0;
          for (int y = int'(esc_pkg::EpochYear); y < yr; y++)
            days += is_leap_year(y) ? 366 : 365;
          secs = longint'(days) * SecsPerDay + $urandom_range(0, 400000) - 200000;
        end
        7: secs = longint'($urandom_range(0, 3 * 366 * SecsPerDay));
        8: secs = longint'(32'h7FFF_FFFF - $urandom_range(0, 40000000));
        default: begin
          days = $urandom_range(0, 24854);
          case ($urandom_range(0, 2))
            0: secs = longint'(days) * SecsPerDay;
            1: secs = longint'(days) * SecsPerDay + 1;
            default: secs = longint'(days) * SecsPerDay + SecsPerDay - 1;
          endcase
        end
      endcase
      send_request(secs[30:0], pick_gap(quiet));
      if ($urandom_range(0, 99) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d conversion requests, checked %0d results", requests_sent,
             date_board.checked);
    $display("Years covered %0d..%0d, %0d results fell on February 29",
             date_board.first_year, date_board.last_year, date_board.leap_days);
    if (date_board.mismatches == 0 && date_board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
